// ===== src/tt_pkg.sv =====
// ----------------------------------------------------------------------------
// tt_pkg: shared types and codes of the transposition table
// Operation and bound codes, fixed field widths and the control groups that
// pass between the table RAM, the probe stage and the top level.
// ----------------------------------------------------------------------------
package tt_pkg;

    // Fixed field widths
    localparam int KEY_WIDTH   = 64;
    localparam int DEPTH_WIDTH = 8;
    localparam int BOUND_WIDTH = 2;

    // Operation codes
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_PROBE = 1'b1;

    // Bound kinds held with an entry
    localparam logic [BOUND_WIDTH-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_WIDTH-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_WIDTH-1:0] BOUND_LOWER = 2'd2;

    // RAM access control
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

    // Probe stage status toward the top level
    typedef struct packed {
        logic ready;   // stage can take a new probe this cycle
        logic busy;    // a probe waits in the compare stage
    } stage_stat_t;

endpackage

// ===== src/transposition_table.sv =====
// ----------------------------------------------------------------------------
// transposition_table: direct-mapped, always-replace transposition table
// Store and probe transactions against one single-port table RAM.
// ----------------------------------------------------------------------------
// After reset the block clears the valid bit of every slot, one slot a cycle,
// and holds in_ready low until that pass is done. Then, while the compare
// stage can take a probe, it takes one transaction per cycle: the single RAM
// port does one access per cycle, a write for a store or a read for a probe.
// A store gives no result. For a probe, the RAM read data and the probe
// fields are registered at the accepting edge, and the compare loads the
// output register once that register is free to take the result. The next
// transaction can be accepted while the result waits in that register as
// long as the compare stage can move on.
module transposition_table #(
    parameter int TABLE_ENTRIES = 65536,
    parameter int SCORE_WIDTH   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [tt_pkg::KEY_WIDTH-1:0]        position_key,
    input  logic [tt_pkg::DEPTH_WIDTH-1:0]      search_depth,
    input  logic signed [SCORE_WIDTH-1:0]       store_score,
    input  logic [tt_pkg::BOUND_WIDTH-1:0]      bound_kind,
    input  logic signed [SCORE_WIDTH-1:0]       alpha_bound,
    input  logic signed [SCORE_WIDTH-1:0]       beta_bound,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic signed [SCORE_WIDTH-1:0]       result_score
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = 1 + tt_pkg::KEY_WIDTH + tt_pkg::DEPTH_WIDTH
                           + SCORE_WIDTH + tt_pkg::BOUND_WIDTH;

    logic                clr_busy_reg;
    logic [IDX_W-1:0]    clr_idx_reg;
    logic                accept;
    tt_pkg::ram_ctl_t    ram_ctl;
    logic [IDX_W-1:0]    ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    tt_pkg::stage_stat_t stage_stat;

    // Sweep the table after reset to clear valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == {IDX_W{1'b1}})
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Accept a transaction when the sweep is done and the compare stage is free
    assign in_ready = !clr_busy_reg && stage_stat.ready;
    assign accept   = in_valid && in_ready;

    // Drive the RAM port: sweep write, store write or probe read
    assign ram_ctl.wr_en = clr_busy_reg || (accept && kind == tt_pkg::KIND_STORE);
    assign ram_ctl.rd_en = accept && kind == tt_pkg::KIND_PROBE;
    assign ram_addr      = clr_busy_reg ? clr_idx_reg : position_key[IDX_W-1:0];
    assign ram_wdata     = clr_busy_reg ? '0
                         : {1'b1, position_key, search_depth, store_score, bound_kind};

    tt_ram #(
        .DEPTH      (TABLE_ENTRIES),
        .DATA_WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tt_match #(
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (ram_ctl.rd_en),
        .probe_key    (position_key),
        .probe_depth  (search_depth),
        .probe_alpha  (alpha_bound),
        .probe_beta   (beta_bound),
        .entry        (ram_rdata),
        .stat         (stage_stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .result_score (result_score)
    );

`ifndef ASSERT_OFF
    // No result can exist before the clearing sweep ends
    a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !out_valid)
        else $error("result valid during clearing sweep");

    // A store into an empty pipeline produces no result
    a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == tt_pkg::KIND_STORE && !stage_stat.busy && !out_valid)
        |=> !out_valid)
        else $error("store produced a result");

    // A probe into an empty pipeline waits in the compare stage, then reaches the output
    a_probe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == tt_pkg::KIND_PROBE && !stage_stat.busy && !out_valid)
        |=> stage_stat.busy ##1 out_valid)
        else $error("probe result not delivered on time");

    // A miss carries a zero score
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (result_score == '0))
        else $error("miss with nonzero score");
`endif

endmodule

// ===== src/tt_ram.sv =====
// ----------------------------------------------------------------------------
// tt_ram: single-port table memory
// One access per cycle, write or read; read data is registered, so it is
// valid in the cycle after the read.
// ----------------------------------------------------------------------------
module tt_ram #(
    parameter int DEPTH      = 65536,
    parameter int DATA_WIDTH = 99
) (
    input  logic                     clk,
    input  tt_pkg::ram_ctl_t         ctl,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Write or read the addressed entry
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tt_match.sv =====
// ----------------------------------------------------------------------------
// tt_match: probe compare stage and output register
// Holds the probe fields while the RAM read completes, then checks tag,
// depth and bound against the entry and registers the result transaction.
// ----------------------------------------------------------------------------
module tt_match #(
    parameter int SCORE_WIDTH = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 issue,
    input  logic [tt_pkg::KEY_WIDTH-1:0]         probe_key,
    input  logic [tt_pkg::DEPTH_WIDTH-1:0]       probe_depth,
    input  logic signed [SCORE_WIDTH-1:0]        probe_alpha,
    input  logic signed [SCORE_WIDTH-1:0]        probe_beta,
    input  logic [SCORE_WIDTH+tt_pkg::KEY_WIDTH+tt_pkg::DEPTH_WIDTH
                  +tt_pkg::BOUND_WIDTH:0]        entry,
    output tt_pkg::stage_stat_t                  stat,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 hit,
    output logic signed [SCORE_WIDTH-1:0]        result_score
);

    localparam int SCORE_LSB = tt_pkg::BOUND_WIDTH;
    localparam int DEPTH_LSB = SCORE_LSB + SCORE_WIDTH;
    localparam int KEY_LSB   = DEPTH_LSB + tt_pkg::DEPTH_WIDTH;
    localparam int VALID_BIT = KEY_LSB + tt_pkg::KEY_WIDTH;

    logic                           s1_valid_reg;
    logic [tt_pkg::KEY_WIDTH-1:0]   s1_key_reg;
    logic [tt_pkg::DEPTH_WIDTH-1:0] s1_depth_reg;
    logic signed [SCORE_WIDTH-1:0]  s1_alpha_reg;
    logic signed [SCORE_WIDTH-1:0]  s1_beta_reg;
    logic                           out_valid_reg;
    logic                           hit_reg;
    logic signed [SCORE_WIDTH-1:0]  score_reg;

    logic                           advance;
    logic                           e_valid;
    logic [tt_pkg::KEY_WIDTH-1:0]   e_key;
    logic [tt_pkg::DEPTH_WIDTH-1:0] e_depth;
    logic signed [SCORE_WIDTH-1:0]  e_score;
    logic [tt_pkg::BOUND_WIDTH-1:0] e_bound;
    logic                           hit_next;
    logic signed [SCORE_WIDTH-1:0]  score_next;

    // Unpack the entry read from the table
    assign e_valid = entry[VALID_BIT];
    assign e_key   = entry[VALID_BIT-1:KEY_LSB];
    assign e_depth = entry[KEY_LSB-1:DEPTH_LSB];
    assign e_score = $signed(entry[DEPTH_LSB-1:SCORE_LSB]);
    assign e_bound = entry[SCORE_LSB-1:0];

    // Move the held probe on when the output register is free
    assign advance    = !out_valid_reg || out_ready;
    assign stat.ready = advance || !s1_valid_reg;
    assign stat.busy  = s1_valid_reg;

    // Resolve hit and score
    always_comb
    begin
        hit_next   = 1'b0;
        score_next = '0;
        if (e_valid && (e_key == s1_key_reg) && (e_depth >= s1_depth_reg))
        begin
            priority if (e_bound == tt_pkg::BOUND_EXACT)
            begin
                hit_next   = 1'b1;
                score_next = e_score;
            end
            else if (e_bound == tt_pkg::BOUND_UPPER && e_score <= s1_alpha_reg)
            begin
                hit_next   = 1'b1;
                score_next = s1_alpha_reg;
            end
            else if (e_bound == tt_pkg::BOUND_LOWER && e_score >= s1_beta_reg)
            begin
                hit_next   = 1'b1;
                score_next = s1_beta_reg;
            end
            else
            begin
                hit_next   = 1'b0;
                score_next = '0;
            end
        end
    end

    // Hold probe fields during the RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_key_reg   <= probe_key;
            s1_depth_reg <= probe_depth;
            s1_alpha_reg <= probe_alpha;
            s1_beta_reg  <= probe_beta;
        end
    end

    // Output register: load a resolved probe, drop on acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            hit_reg   <= hit_next;
            score_reg <= score_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign result_score = score_reg;

endmodule
